/* rtl/ehp_pkg.sv */
`default_nettype none

package ehp_pkg;

    // EC RAM geometry
    localparam int RAM_DEPTH = 256;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // host command bytes
    localparam logic [7:0] CMD_READ  = 8'h80;
    localparam logic [7:0] CMD_WRITE = 8'h81;

    // status byte bits
    localparam logic [7:0] STS_OBF = 8'h01;
    localparam logic [7:0] STS_IBF = 8'h02;

    // port address reset values
    localparam logic [15:0] CMD_PORT_RESET  = 16'h0066;
    localparam logic [15:0] DATA_PORT_RESET = 16'h0062;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_PORT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_PORT = 8'd1;

    // access class decided by the front end
    typedef enum logic [2:0] {
        OP_MISS,
        OP_STATUS_RD,
        OP_DATA_RD,
        OP_CMD_WR,
        OP_DATA_WR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] wd;
    } item_t;

endpackage

`default_nettype wire

/* rtl/ehp_ram.sv */
`default_nettype none

module ehp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ehp_front.sv */
`default_nettype none

module ehp_front
    import ehp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // host access stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic                 s_tuser,
    // config writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    // to queue
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output item_t                     push_item
);

    logic [15:0] cmd_port_reg,  cmd_port_next;
    logic [15:0] data_port_reg, data_port_next;

    logic [15:0] addr;
    logic        is_write;

    assign addr     = s_tdata[15:0];
    assign is_write = s_tuser;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd_port_next  = cmd_port_reg;
        data_port_next = data_port_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_CMD_PORT)
            begin
                cmd_port_next = cfg_data;
            end
            else if (cfg_index == CFG_DATA_PORT)
            begin
                data_port_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_port_reg  <= CMD_PORT_RESET;
            data_port_reg <= DATA_PORT_RESET;
        end
        else
        begin
            cmd_port_reg  <= cmd_port_next;
            data_port_reg <= data_port_next;
        end
    end

    // command port wins when both decode to one address
    always_comb
    begin
        push_item.wd = s_tdata[23:16];
        if (addr == cmd_port_reg)
        begin
            push_item.op = is_write ? OP_CMD_WR : OP_STATUS_RD;
        end
        else if (addr == data_port_reg)
        begin
            push_item.op = is_write ? OP_DATA_WR : OP_DATA_RD;
        end
        else
        begin
            push_item.op = OP_MISS;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

/* rtl/ehp_fifo.sv */
`default_nettype none

module ehp_fifo
    import ehp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    item_t       slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/ehp_back.sv */
`default_nettype none

module ehp_back
    import ehp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // from queue
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire item_t       pop_item,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RD_INDEX,
        PH_WR_INDEX,
        PH_WR_DATA
    } phase_t;

    localparam logic [8:0] DEPTH_LIM = 9'(RAM_DEPTH);

    phase_t               phase_reg,     phase_next;
    logic [7:0]           ram_index_reg, ram_index_next;
    logic [7:0]           out_byte_reg,  out_byte_next;
    logic                 out_full_reg,  out_full_next;
    logic                 load_pend_reg, load_pend_next;
    logic                 load_ok_reg,   load_ok_next;
    logic [RAM_DEPTH-1:0] valid_reg,     valid_next;
    logic                 ovalid_reg,    ovalid_next;
    logic [7:0]           rd_reg,        rd_next;
    logic                 hit_reg,       hit_next;
    logic                 err_reg,       err_next;

    logic             go;
    logic [7:0]       load_byte;
    logic [7:0]       ram_q;
    logic             ram_we;
    logic             head_in_range;
    logic             idx_in_range;

    assign go        = pop_valid && (!ovalid_reg || m_tready);
    assign pop_ready = go;

    assign head_in_range = ({1'b0, pop_item.wd} < DEPTH_LIM);
    assign idx_in_range  = ({1'b0, ram_index_reg} < DEPTH_LIM);

    // buffer byte, with a RAM load from the previous cycle folded in
    assign load_byte = load_pend_reg ? (load_ok_reg ? ram_q : 8'h00) : out_byte_reg;

    ehp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_index_reg[RAM_AW-1:0]),
        .wdata (pop_item.wd),
        .raddr (pop_item.wd[RAM_AW-1:0]),
        .rdata (ram_q)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        ram_index_next = ram_index_reg;
        out_byte_next  = load_byte;
        out_full_next  = out_full_reg;
        load_pend_next = 1'b0;
        load_ok_next   = load_ok_reg;
        valid_next     = valid_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        rd_next        = rd_reg;
        hit_next       = hit_reg;
        err_next       = err_reg;
        ram_we         = 1'b0;

        if (go)
        begin
            ovalid_next = 1'b1;
            rd_next     = 8'h00;
            hit_next    = 1'b1;
            err_next    = 1'b0;
            case (pop_item.op)
                OP_STATUS_RD:
                begin
                    rd_next = (out_full_reg ? STS_OBF : 8'h00) & ~STS_IBF;
                end
                OP_DATA_RD:
                begin
                    rd_next       = load_byte;
                    out_full_next = 1'b0;
                end
                OP_CMD_WR:
                begin
                    if (pop_item.wd == CMD_READ)
                    begin
                        phase_next = PH_RD_INDEX;
                    end
                    else if (pop_item.wd == CMD_WRITE)
                    begin
                        phase_next = PH_WR_INDEX;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        err_next   = 1'b1;
                    end
                end
                OP_DATA_WR:
                begin
                    case (phase_reg)
                        PH_RD_INDEX:
                        begin
                            ram_index_next = pop_item.wd;
                            load_pend_next = 1'b1;
                            load_ok_next   = head_in_range
                                             && valid_reg[pop_item.wd[RAM_AW-1:0]];
                            out_full_next  = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        PH_WR_INDEX:
                        begin
                            ram_index_next = pop_item.wd;
                            phase_next     = PH_WR_DATA;
                        end
                        PH_WR_DATA:
                        begin
                            if (idx_in_range)
                            begin
                                ram_we = 1'b1;
                                valid_next[ram_index_reg[RAM_AW-1:0]] = 1'b1;
                            end
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ram_index_reg <= 8'h00;
            out_byte_reg  <= 8'h00;
            out_full_reg  <= 1'b0;
            load_pend_reg <= 1'b0;
            load_ok_reg   <= 1'b0;
            valid_reg     <= '0;
            ovalid_reg    <= 1'b0;
            rd_reg        <= 8'h00;
            hit_reg       <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ram_index_reg <= ram_index_next;
            out_byte_reg  <= out_byte_next;
            out_full_reg  <= out_full_next;
            load_pend_reg <= load_pend_next;
            load_ok_reg   <= load_ok_next;
            valid_reg     <= valid_next;
            ovalid_reg    <= ovalid_next;
            rd_reg        <= rd_next;
            hit_reg       <= hit_next;
            err_reg       <= err_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = rd_reg;
    assign m_tuser  = {err_reg, hit_reg};

endmodule

`default_nettype wire

/* rtl/ec_host_port_ram_access.sv */
`default_nettype none

// Channel   | Dir | Handshake             | Payload
// ----------+-----+-----------------------+-----------------------------------------
// s_        | in  | s_tvalid / s_tready   | tdata: port_addr, write_data; tuser: opcode
// m_        | out | m_tvalid / m_tready   | tdata: read_data; tuser: port_hit, proto_error
// cfg_      | in  | cfg_valid / cfg_ready | cfg_index (0 cmd port, 1 data port), cfg_data
//
// Sustained rate is one item per cycle while m_tready is high; the back end retires
// one queued item per cycle into the output register when that register is free.
// m_tvalid rises once the item is written into the queue and then executed into the
// output register. A RAM index load issues the read on the RAM port and folds
// the registered read data into the output buffer the next cycle, with no stall.
// Reset: per-entry valid bits make every RAM entry read as zero until written;
// there is no clearing pass. m_tready low stalls the back end only; the two-entry
// queue keeps accepting until full. cfg_ready is always high.

module ec_host_port_ram_access
    import ehp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // host access items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // [15:0] port_addr, [23:16] write_data
    input  wire logic                 s_tuser,   // [0] opcode (1 = write)
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] read_data
    output logic [1:0]                m_tuser,   // [0] port_hit, [1] proto_error
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // front: port decode against the address registers
    ehp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue between decode and execute
    ehp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: protocol phase, EC RAM, output buffer, result register
    ehp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
